// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the rtl assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/fifp_pkg.sv -----
// ----------------------------------------------------------------------------
// fifp_pkg
// character codes and helpers for the integer field parser
// ----------------------------------------------------------------------------
`default_nettype none

package fifp_pkg;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_X_LO  = 8'h78;
    localparam logic [7:0] CHAR_X_UP  = 8'h58;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // digit value of a character, DIGIT_NONE when not a hex digit
    localparam logic [4:0] DIGIT_NONE = 5'd31;

    // magnitude saturates here, one past the 32-bit unsigned range
    localparam logic [32:0] MAG_CAP = 33'h1_0000_0000;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        begin
            if (c inside {[8'h30:8'h39]})
                d = {1'b0, c[3:0]};
            else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
                d = 5'(c[3:0]) + 5'd9;
            else
                d = DIGIT_NONE;
            return d;
        end
    endfunction

    // saturating conversion of sign and magnitude to a 32-bit value
    function automatic logic [31:0] current_value(input logic neg, input logic [32:0] mag);
        logic [31:0] v;
        begin
            if (neg)
                v = (mag >= 33'h0_8000_0000) ? 32'h8000_0000 : (~mag[31:0]) + 32'd1;
            else
                v = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/free_format_integer_field_parser.sv -----
// ----------------------------------------------------------------------------
// free_format_integer_field_parser
// decodes up to three integers from a character stream, one line per result
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one character per transaction
//   with has_char and last_char flags; last_char closes the line
//   output channel (out_valid / out_stall) carries one transaction per line:
//   the three values and the bad_char flag
//   throughput: one character per cycle, but a final character is held while
//   the result register is full and stalled
//   a result passes the input register, then the parse state and result register
//   reset clears the parse state and both valid flags; the next line starts
//   from field zero
//   a stalled result holds; characters other than the final one keep flowing
//   while the result waits, and a final character waits in the input register
//   with in_stall high until the result register frees up
// ----------------------------------------------------------------------------
`default_nettype none

module free_format_integer_field_parser
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         char_code,
    input  wire logic               has_char,
    input  wire logic               last_char,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      first_value,
    output logic signed [31:0]      second_value,
    output logic signed [31:0]      third_value,
    output logic                    bad_char
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    typedef struct packed {
        logic [1:0]  field_index;
        phase_t      phase;
        base_t       base;
        logic [32:0] magnitude;
        logic        is_negative;
        logic        error_seen;
        logic [31:0] saved0;
        logic [31:0] saved1;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        field_index: 2'd0,
        phase:       PH_SKIP,
        base:        BASE_DEC,
        magnitude:   33'd0,
        is_negative: 1'b0,
        error_seen:  1'b0,
        saved0:      32'd0,
        saved1:      32'd0
    };

    function automatic logic [32:0] accumulate(input logic [32:0] mag, input base_t base,
                                               input logic [4:0] d);
        logic [36:0] m;
        logic [36:0] prod;
        begin
            m = 37'(mag);
            case (base)
                BASE_HEX: prod = m << 4;
                BASE_OCT: prod = m << 3;
                default:  prod = (m << 3) + (m << 1);
            endcase
            prod = prod + 37'(d);
            return (prod > 37'(fifp_pkg::MAG_CAP)) ? fifp_pkg::MAG_CAP : prod[32:0];
        end
    endfunction

    function automatic parse_state_t raise_error(input parse_state_t s);
        parse_state_t r;
        begin
            r = s;
            r.error_seen = 1'b1;
            r.phase      = PH_DONE;
            return r;
        end
    endfunction

    function automatic parse_state_t close_token(input parse_state_t s);
        parse_state_t r;
        logic [31:0]  cv;
        begin
            r  = s;
            cv = fifp_pkg::current_value(s.is_negative, s.magnitude);
            if (s.phase == PH_LEAD || s.phase == PH_SIGNED || s.phase == PH_HEXPFX) begin
                r = raise_error(s);
            end
            else if (s.field_index < 2'd2) begin
                if (s.field_index[0])
                    r.saved1 = cv;
                else
                    r.saved0 = cv;
                r.field_index = s.field_index + 2'd1;
                r.magnitude   = 33'd0;
                r.is_negative = 1'b0;
                r.base        = BASE_DEC;
                r.phase       = PH_SKIP;
            end
            else begin
                r.phase = PH_DONE;
            end
            return r;
        end
    endfunction

    function automatic parse_state_t take_char(input parse_state_t s, input logic [7:0] c);
        parse_state_t r;
        logic [4:0]   d;
        logic [4:0]   lim;
        logic         go;
        begin
            r  = s;
            d  = fifp_pkg::digit_of(c);
            go = 1'b1;
            if (s.phase == PH_DONE) begin
                go = 1'b0;
            end
            else if (s.phase == PH_SKIP) begin
                if (c == fifp_pkg::CHAR_SPACE) begin
                    go = 1'b0;
                end
                else if (c == fifp_pkg::CHAR_COMMA) begin
                    r.phase = PH_DONE;
                    go      = 1'b0;
                end
                else begin
                    r.phase = PH_LEAD;
                end
            end
            else if (c == fifp_pkg::CHAR_SPACE || c == fifp_pkg::CHAR_COMMA) begin
                r  = close_token(s);
                go = 1'b0;
            end

            // leading whitespace and sign, then falls into the first digit
            if (go && r.phase == PH_LEAD) begin
                if (c inside {[fifp_pkg::CHAR_TAB:fifp_pkg::CHAR_CR]}) begin
                    go = 1'b0;
                end
                else begin
                    r.phase = PH_SIGNED;
                    if (c == fifp_pkg::CHAR_PLUS) begin
                        go = 1'b0;
                    end
                    else if (c == fifp_pkg::CHAR_MINUS) begin
                        r.is_negative = 1'b1;
                        go            = 1'b0;
                    end
                end
            end

            if (go) begin
                case (r.phase)
                    PH_SIGNED:
                    begin
                        if (c == fifp_pkg::CHAR_ZERO) begin
                            r.base  = BASE_OCT;
                            r.phase = PH_ZERO;
                        end
                        else if (c inside {[fifp_pkg::CHAR_ONE:fifp_pkg::CHAR_NINE]}) begin
                            r.base      = BASE_DEC;
                            r.magnitude = 33'(d);
                            r.phase     = PH_DIGITS;
                        end
                        else begin
                            r = raise_error(r);
                        end
                    end
                    PH_ZERO:
                    begin
                        if (c == fifp_pkg::CHAR_X_LO || c == fifp_pkg::CHAR_X_UP) begin
                            r.base  = BASE_HEX;
                            r.phase = PH_HEXPFX;
                        end
                        else if (d < 5'd8) begin
                            r.magnitude = accumulate(r.magnitude, r.base, d);
                            r.phase     = PH_DIGITS;
                        end
                        else begin
                            r = raise_error(r);
                        end
                    end
                    PH_HEXPFX:
                    begin
                        if (d < 5'd16) begin
                            r.magnitude = accumulate(r.magnitude, r.base, d);
                            r.phase     = PH_DIGITS;
                        end
                        else begin
                            r = raise_error(r);
                        end
                    end
                    PH_DIGITS:
                    begin
                        case (r.base)
                            BASE_HEX: lim = 5'd16;
                            BASE_OCT: lim = 5'd8;
                            default:  lim = 5'd10;
                        endcase
                        if (d < lim)
                            r.magnitude = accumulate(r.magnitude, r.base, d);
                        else
                            r = raise_error(r);
                    end
                    default:
                    begin
                        r = r;
                    end
                endcase
            end
            return r;
        end
    endfunction

    // input register
    logic         s1_valid_reg;
    logic [7:0]   char_reg;
    logic         has_reg;
    logic         last_reg;

    // parse state and result register
    parse_state_t st_reg;
    logic         out_valid_reg;
    logic [31:0]  first_reg;
    logic [31:0]  second_reg;
    logic [31:0]  third_reg;
    logic         bad_reg;

    parse_state_t st_char;
    parse_state_t st_end;
    logic [31:0]  end_cv;
    logic [31:0]  first_next;
    logic [31:0]  second_next;
    logic [31:0]  third_next;
    logic         out_free;
    logic         s1_adv;
    logic         in_take;

    // a final character may only leave the input register when the result has room
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        st_char = has_reg ? take_char(st_reg, char_reg) : st_reg;
        if (st_char.phase != PH_SKIP && st_char.phase != PH_DONE)
            st_end = close_token(st_char);
        else
            st_end = st_char;
        end_cv = fifp_pkg::current_value(st_end.is_negative, st_end.magnitude);

        case (st_end.field_index)
            2'd0:
            begin
                first_next  = end_cv;
                second_next = 32'd0;
                third_next  = 32'd0;
            end
            2'd1:
            begin
                first_next  = st_end.saved0;
                second_next = end_cv;
                third_next  = 32'd0;
            end
            2'd2:
            begin
                first_next  = st_end.saved0;
                second_next = st_end.saved1;
                third_next  = end_cv;
            end
            default:
            begin
                first_next  = st_end.saved0;
                second_next = st_end.saved1;
                third_next  = st_end.saved0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= PARSE_RESET;
        end
        else begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv) begin
                st_reg <= last_reg ? PARSE_RESET : st_char;
            end

            if (s1_adv && last_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            char_reg <= char_code;
            has_reg  <= has_char;
            last_reg <= last_char;
        end
        if (s1_adv && last_reg) begin
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            bad_reg    <= st_end.error_seen;
        end
    end

    assign out_valid    = out_valid_reg;
    assign first_value  = $signed(first_reg);
    assign second_value = $signed(second_reg);
    assign third_value  = $signed(third_reg);
    assign bad_char     = bad_reg;

    `ASSERT_CLK(a_mid_line_never_stalls, clk, rst_n, (s1_valid_reg && !last_reg) |-> !in_stall, "character inside a line stalled the input")
    `ASSERT_CLK(a_line_end_gives_result, clk, rst_n, (s1_adv && last_reg) |=> out_valid, "line end did not produce a result")
    `ASSERT_CLK(a_line_end_resets_parse, clk, rst_n, (s1_adv && last_reg) |=> (st_reg.phase == PH_SKIP && st_reg.field_index == 2'd0), "parse state not cleared after line end")
    `ASSERT_CLK(a_field_index_range, clk, rst_n, st_reg.field_index != 2'd3, "field index out of range")
    `ASSERT_CLK(a_magnitude_capped, clk, rst_n, st_reg.magnitude <= fifp_pkg::MAG_CAP, "magnitude above saturation cap")
    `ASSERT_ALWAYS(a_reset_clears_result, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

`default_nettype wire
